[design/ncrs_pkg.sv]
`default_nettype none
package ncrs_pkg;

	// Default limits
	localparam int          MAX_HASHES_DEF       = 255;
	localparam int          MAX_NESTING_DEF      = 255;
	localparam logic [31:0] MAX_TOKEN_LENGTH_DEF = 32'd65535;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Field widths
	localparam int CH_W   = 21;
	localparam int KIND_W = 2;
	localparam int LEN_W  = 16;

	// Characters of interest
	localparam logic [CH_W-1:0] CH_NUL    = 21'h00;
	localparam logic [CH_W-1:0] CH_TAB    = 21'h09;
	localparam logic [CH_W-1:0] CH_NL     = 21'h0A;
	localparam logic [CH_W-1:0] CH_CR     = 21'h0D;
	localparam logic [CH_W-1:0] CH_SPACE  = 21'h20;
	localparam logic [CH_W-1:0] CH_QUOTE  = 21'h22;
	localparam logic [CH_W-1:0] CH_HASH   = 21'h23;
	localparam logic [CH_W-1:0] CH_STAR   = 21'h2A;
	localparam logic [CH_W-1:0] CH_SLASH  = 21'h2F;
	localparam logic [CH_W-1:0] CH_B      = 21'h62;
	localparam logic [CH_W-1:0] CH_R      = 21'h72;
	localparam logic [CH_W-1:0] CH_RBRACE = 21'h7D;

	// Character classes produced by the front
	localparam int CLS_W = 4;
	typedef logic [CLS_W-1:0] cls_t;
	localparam cls_t CLS_OTHER  = 4'd0;
	localparam cls_t CLS_NUL    = 4'd1;
	localparam cls_t CLS_BLANK  = 4'd2;
	localparam cls_t CLS_NL     = 4'd3;
	localparam cls_t CLS_RBRACE = 4'd4;
	localparam cls_t CLS_HASH   = 4'd5;
	localparam cls_t CLS_QUOTE  = 4'd6;
	localparam cls_t CLS_SLASH  = 4'd7;
	localparam cls_t CLS_STAR   = 4'd8;
	localparam cls_t CLS_R      = 4'd9;
	localparam cls_t CLS_B      = 4'd10;

	// Token kinds
	localparam logic [KIND_W-1:0] KIND_SEMI    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_COMMENT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RAW     = 2'd2;

	// Classified item passed from front to back
	typedef struct packed {
		logic start;
		logic semi;
		logic raw;
		logic at_range;
		cls_t cls;
	} item_t;

endpackage
`default_nettype wire

[design/nested_comment_raw_string_scanner_top.sv]
// Nested block comment and raw string scanner.
//
// Input channel (in_valid/in_ready): one character per item with its start
// flag, the semicolon and raw-string permissions (taken with start) and the
// range-start mark. Output channel (out_valid/out_ready): one result item
// when a scan decides - accepted, token kind, token length, skipped blanks.
// Characters that do not end a scan produce no result item.
//
// Throughput: one item per cycle while the output register is free or
// draining; the scanner step updates its counters from the head of a
// four-entry queue. A deciding item is written into the queue when accepted
// and the scanner loads the result register when it takes that item.
//
// Reset empties the queue, sets the scan state to idle and clears out_valid.
// When the receiver stalls, the result waits in the output register; the
// scanner stops taking items from the queue and in_ready drops once the
// queue is full. No item is lost or repeated.
`default_nettype none
module nested_comment_raw_string_scanner_top #(
	parameter int          MAX_HASHES       = ncrs_pkg::MAX_HASHES_DEF,
	parameter int          MAX_NESTING      = ncrs_pkg::MAX_NESTING_DEF,
	parameter logic [31:0] MAX_TOKEN_LENGTH = ncrs_pkg::MAX_TOKEN_LENGTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          start_req,
	input  wire logic                          valid_semicolon,
	input  wire logic                          valid_raw_string,
	input  wire logic [ncrs_pkg::CH_W-1:0]     ch,
	input  wire logic                          at_range_start,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               accepted,
	output logic [ncrs_pkg::KIND_W-1:0]        token_kind,
	output logic [ncrs_pkg::LEN_W-1:0]         token_length,
	output logic [ncrs_pkg::LEN_W-1:0]         skipped_count
);

	ncrs_pkg::item_t front_item;
	ncrs_pkg::item_t head_item;
	logic            head_valid;
	logic            pop;

	ncrs_front u_front (
		.start_req        (start_req),
		.valid_semicolon  (valid_semicolon),
		.valid_raw_string (valid_raw_string),
		.ch               (ch),
		.at_range_start   (at_range_start),
		.item             (front_item)
	);

	ncrs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid),
		.push_item (front_item),
		.not_full  (in_ready),
		.pop       (pop),
		.head_item (head_item),
		.not_empty (head_valid)
	);

	ncrs_back #(
		.MAX_HASHES       (MAX_HASHES),
		.MAX_NESTING      (MAX_NESTING),
		.MAX_TOKEN_LENGTH (MAX_TOKEN_LENGTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_item     (head_item),
		.head_valid    (head_valid),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.accepted      (accepted),
		.token_kind    (token_kind),
		.token_length  (token_length),
		.skipped_count (skipped_count)
	);

endmodule
`default_nettype wire

[design/ncrs_front.sv]
`default_nettype none
module ncrs_front (
	input  wire logic                        start_req,
	input  wire logic                        valid_semicolon,
	input  wire logic                        valid_raw_string,
	input  wire logic [ncrs_pkg::CH_W-1:0]   ch,
	input  wire logic                        at_range_start,
	output ncrs_pkg::item_t                  item
);

	logic is_blank;

	// Blanks: space and tab through carriage return
	assign is_blank = (ch == ncrs_pkg::CH_SPACE) ||
	                  ((ch >= ncrs_pkg::CH_TAB) && (ch <= ncrs_pkg::CH_CR));

	// Reduce the code point to the class the scanner cares about
	always_comb begin
		item.start    = start_req;
		item.semi     = valid_semicolon;
		item.raw      = valid_raw_string;
		item.at_range = at_range_start;
		if (ch == ncrs_pkg::CH_NUL)
			item.cls = ncrs_pkg::CLS_NUL;
		else if (ch == ncrs_pkg::CH_NL)
			item.cls = ncrs_pkg::CLS_NL;
		else if (is_blank)
			item.cls = ncrs_pkg::CLS_BLANK;
		else if (ch == ncrs_pkg::CH_RBRACE)
			item.cls = ncrs_pkg::CLS_RBRACE;
		else if (ch == ncrs_pkg::CH_HASH)
			item.cls = ncrs_pkg::CLS_HASH;
		else if (ch == ncrs_pkg::CH_QUOTE)
			item.cls = ncrs_pkg::CLS_QUOTE;
		else if (ch == ncrs_pkg::CH_SLASH)
			item.cls = ncrs_pkg::CLS_SLASH;
		else if (ch == ncrs_pkg::CH_STAR)
			item.cls = ncrs_pkg::CLS_STAR;
		else if (ch == ncrs_pkg::CH_R)
			item.cls = ncrs_pkg::CLS_R;
		else if (ch == ncrs_pkg::CH_B)
			item.cls = ncrs_pkg::CLS_B;
		else
			item.cls = ncrs_pkg::CLS_OTHER;
	end

endmodule
`default_nettype wire

[design/ncrs_queue.sv]
`default_nettype none
module ncrs_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire ncrs_pkg::item_t push_item,
	output logic                 not_full,
	input  wire logic            pop,
	output ncrs_pkg::item_t      head_item,
	output logic                 not_empty
);

	localparam int DEPTH = ncrs_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	ncrs_pkg::item_t  slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign not_full  = (count_q != CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && not_full;
	assign do_pop    = pop && not_empty;
	assign head_item = slot_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_item;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

[design/ncrs_back.sv]
`default_nettype none
module ncrs_back #(
	parameter int          MAX_HASHES       = ncrs_pkg::MAX_HASHES_DEF,
	parameter int          MAX_NESTING      = ncrs_pkg::MAX_NESTING_DEF,
	parameter logic [31:0] MAX_TOKEN_LENGTH = ncrs_pkg::MAX_TOKEN_LENGTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire ncrs_pkg::item_t               head_item,
	input  wire logic                          head_valid,
	output logic                               pop,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               accepted,
	output logic [ncrs_pkg::KIND_W-1:0]        token_kind,
	output logic [ncrs_pkg::LEN_W-1:0]         token_length,
	output logic [ncrs_pkg::LEN_W-1:0]         skipped_count
);

	localparam int HASH_W  = $clog2(MAX_HASHES + 1);
	localparam int DEPTH_W = $clog2(MAX_NESTING + 1);
	localparam int LEN_W   = ncrs_pkg::LEN_W;
	localparam logic [LEN_W-1:0] LEN_CAP = (MAX_TOKEN_LENGTH < 32'd65535) ?
	                                       MAX_TOKEN_LENGTH[LEN_W-1:0] : '1;
	localparam logic [LEN_W-1:0] SKIP_CAP = '1;
	localparam logic [HASH_W-1:0]  HASH_LIMIT  = HASH_W'(MAX_HASHES);
	localparam logic [DEPTH_W-1:0] DEPTH_LIMIT = DEPTH_W'(MAX_NESTING);

	// Scan phases
	localparam logic [3:0] PH_IDLE        = 4'd0;
	localparam logic [3:0] PH_SEMI        = 4'd1;
	localparam logic [3:0] PH_LEAD        = 4'd2;
	localparam logic [3:0] PH_AFTER_B     = 4'd3;
	localparam logic [3:0] PH_HASHES      = 4'd4;
	localparam logic [3:0] PH_BODY        = 4'd5;
	localparam logic [3:0] PH_CLOSE       = 4'd6;
	localparam logic [3:0] PH_AFTER_SLASH = 4'd7;
	localparam logic [3:0] PH_COMMENT     = 4'd8;
	localparam logic [3:0] PH_NEST_CHECK  = 4'd9;

	logic [3:0]         phase_q;
	logic [HASH_W-1:0]  open_hashes_q;
	logic [HASH_W-1:0]  close_hashes_q;
	logic [DEPTH_W-1:0] comment_depth_q;
	logic               star_seen_q;
	logic               raw_allowed_q;
	logic [LEN_W-1:0]   length_count_q;
	logic [LEN_W-1:0]   skip_count_q;

	logic [3:0]         ph_d;
	logic [HASH_W-1:0]  open_d;
	logic [HASH_W-1:0]  close_d;
	logic [DEPTH_W-1:0] depth_d;
	logic               star_d;
	logic               raw_d;
	logic [LEN_W-1:0]   len_d;
	logic [LEN_W-1:0]   skip_d;
	logic               emit;
	logic               emit_ok;
	logic [ncrs_pkg::KIND_W-1:0] emit_kind;

	logic out_valid_q;
	logic accepted_q;
	logic [ncrs_pkg::KIND_W-1:0] token_kind_q;
	logic [LEN_W-1:0] token_length_q;
	logic [LEN_W-1:0] skipped_count_q;

	// The back takes an item whenever the output register is free or draining
	assign pop = head_valid && (!out_valid_q || out_ready);

	// One scanner step on the head item
	always_comb begin
		ncrs_pkg::cls_t   c;
		logic             blank;
		logic [LEN_W-1:0] len_inc;
		logic [LEN_W-1:0] skip_inc;
		logic             close_step;
		logic             nest_step;
		logic [HASH_W-1:0]  close_nxt;
		logic [DEPTH_W-1:0] depth_dec;

		c = head_item.cls;
		blank = (c == ncrs_pkg::CLS_BLANK) || (c == ncrs_pkg::CLS_NL);

		ph_d    = phase_q;
		open_d  = open_hashes_q;
		close_d = close_hashes_q;
		depth_d = comment_depth_q;
		star_d  = star_seen_q;
		raw_d   = raw_allowed_q;
		len_d   = length_count_q;
		skip_d  = skip_count_q;
		emit      = 1'b0;
		emit_ok   = 1'b0;
		emit_kind = ncrs_pkg::KIND_SEMI;

		// A start flag drops any open scan and begins afresh with this item
		if (head_item.start) begin
			open_d  = '0;
			close_d = '0;
			depth_d = '0;
			star_d  = 1'b0;
			len_d   = '0;
			skip_d  = '0;
			raw_d   = head_item.raw;
			ph_d    = head_item.semi ? PH_SEMI : PH_LEAD;
		end

		len_inc    = (len_d < LEN_CAP) ? len_d + 1'b1 : len_d;
		skip_inc   = (skip_d < SKIP_CAP) ? skip_d + 1'b1 : skip_d;
		close_nxt  = close_d + 1'b1;
		depth_dec  = (depth_d != '0) ? depth_d - 1'b1 : depth_d;
		close_step = (ph_d == PH_CLOSE) && (c == ncrs_pkg::CLS_HASH) && (close_d < open_d);
		nest_step  = (ph_d == PH_NEST_CHECK) && (c == ncrs_pkg::CLS_STAR);

		unique case (ph_d)
			PH_SEMI: begin
				if ((c == ncrs_pkg::CLS_NUL) || (c == ncrs_pkg::CLS_RBRACE) ||
				    head_item.at_range) begin
					emit = 1'b1; emit_ok = 1'b1;
				end else if (c == ncrs_pkg::CLS_NL) begin
					skip_d = skip_inc;
					emit = 1'b1; emit_ok = 1'b1;
				end else if (!blank) begin
					emit = 1'b1;
				end else begin
					skip_d = skip_inc;
				end
			end
			PH_LEAD: begin
				if (blank) begin
					skip_d = skip_inc;
				end else if (raw_d && ((c == ncrs_pkg::CLS_R) || (c == ncrs_pkg::CLS_B))) begin
					len_d = len_inc;
					ph_d  = (c == ncrs_pkg::CLS_B) ? PH_AFTER_B : PH_HASHES;
				end else if (c == ncrs_pkg::CLS_SLASH) begin
					len_d = len_inc;
					ph_d  = PH_AFTER_SLASH;
				end else begin
					emit = 1'b1;
				end
			end
			PH_AFTER_B: begin
				if (c == ncrs_pkg::CLS_R) begin
					len_d = len_inc;
					ph_d  = PH_HASHES;
				end else begin
					emit = 1'b1;
				end
			end
			PH_HASHES: begin
				if (c == ncrs_pkg::CLS_HASH) begin
					if (open_d >= HASH_LIMIT) begin
						emit = 1'b1;
					end else begin
						open_d = open_d + 1'b1;
						len_d  = len_inc;
					end
				end else if (c == ncrs_pkg::CLS_QUOTE) begin
					len_d = len_inc;
					ph_d  = PH_BODY;
				end else begin
					emit = 1'b1;
				end
			end
			PH_BODY, PH_CLOSE: begin
				// A closing hash, a NUL that ends the scan unaccepted, or else the character falls back into the body
				if (close_step) begin
					len_d   = len_inc;
					close_d = close_nxt;
					if (close_nxt == open_d) begin
						emit = 1'b1; emit_ok = 1'b1; emit_kind = ncrs_pkg::KIND_RAW;
					end
				end else if (c == ncrs_pkg::CLS_NUL) begin
					emit = 1'b1;
				end else begin
					len_d = len_inc;
					ph_d  = PH_BODY;
					if (c == ncrs_pkg::CLS_QUOTE) begin
						close_d = '0;
						if (open_d == '0) begin
							emit = 1'b1; emit_ok = 1'b1; emit_kind = ncrs_pkg::KIND_RAW;
						end else begin
							ph_d = PH_CLOSE;
						end
					end
				end
			end
			PH_AFTER_SLASH: begin
				if (c == ncrs_pkg::CLS_STAR) begin
					len_d   = len_inc;
					depth_d = DEPTH_W'(1);
					star_d  = 1'b0;
					ph_d    = PH_COMMENT;
				end else begin
					emit = 1'b1;
				end
			end
			PH_COMMENT, PH_NEST_CHECK: begin
				// Slash then star opens a nested level (rejected at the limit); a NUL rejects; otherwise comment body
				if (nest_step) begin
					if (depth_d >= DEPTH_LIMIT) begin
						emit = 1'b1;
					end else begin
						depth_d = depth_d + 1'b1;
						len_d   = len_inc;
						ph_d    = PH_COMMENT;
					end
				end else if (c == ncrs_pkg::CLS_NUL) begin
					emit = 1'b1;
				end else begin
					len_d = len_inc;
					ph_d  = PH_COMMENT;
					if (c == ncrs_pkg::CLS_STAR) begin
						star_d = 1'b1;
					end else if (c == ncrs_pkg::CLS_SLASH) begin
						if (star_d) begin
							star_d  = 1'b0;
							depth_d = depth_dec;
							if (depth_dec == '0) begin
								emit = 1'b1; emit_ok = 1'b1;
								emit_kind = ncrs_pkg::KIND_COMMENT;
							end
						end else begin
							ph_d = PH_NEST_CHECK;
						end
					end else begin
						star_d = 1'b0;
					end
				end
			end
			default: begin
				ph_d = PH_IDLE;
			end
		endcase

		if (emit)
			ph_d = PH_IDLE;
	end

	// Scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			open_hashes_q   <= '0;
			close_hashes_q  <= '0;
			comment_depth_q <= '0;
			star_seen_q     <= 1'b0;
			raw_allowed_q   <= 1'b0;
			length_count_q  <= '0;
			skip_count_q    <= '0;
		end else if (pop) begin
			phase_q         <= ph_d;
			open_hashes_q   <= open_d;
			close_hashes_q  <= close_d;
			comment_depth_q <= depth_d;
			star_seen_q     <= star_d;
			raw_allowed_q   <= raw_d;
			length_count_q  <= len_d;
			skip_count_q    <= skip_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			accepted_q      <= emit_ok;
			token_kind_q    <= emit_ok ? emit_kind : ncrs_pkg::KIND_SEMI;
			token_length_q  <= emit_ok ? len_d : '0;
			skipped_count_q <= skip_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign accepted      = accepted_q;
	assign token_kind    = token_kind_q;
	assign token_length  = token_length_q;
	assign skipped_count = skipped_count_q;

endmodule
`default_nettype wire
